/* rtl/crc16hx_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and CRC/hex helpers for the CRC-16 hex trailer checker.
// No dependencies; imported by every module of the block.
package crc16hx_pkg;

	localparam int TRAILER_BYTES_DEF = 6;
	localparam int CMP_DIGITS        = 4;   // trailer characters compared as hex
	localparam int QDEPTH            = 2;   // front-to-back queue depth, power of two

	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] POLY_CCITT  = 16'h1021;
	localparam logic [15:0] POLY_MODBUS = 16'hA001;

	// register indexes (word address = 4 * index)
	localparam logic REG_CRC_MODE = 1'b0;

	typedef enum logic [1:0] {
		ST_MATCH    = 2'd0,
		ST_MISMATCH = 2'd1,
		ST_SHORT    = 2'd2
	} status_t;

	// one classified character handed from front to back
	typedef struct packed {
		logic                       crc_en;      // a delayed character enters the CRC
		logic [7:0]                 crc_byte;
		logic                       modbus;
		logic                       last;
		logic                       short_frame;
		logic [CMP_DIGITS-1:0][7:0] trailer;     // first trailer characters, valid on last
	} entry_t;

	localparam logic [7:0] HEX_CHAR [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	// one-byte CRC update, unrolled bit steps
	function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b, logic modbus);
		logic [15:0] c;
		c = modbus ? (crc ^ {8'h00, b}) : (crc ^ {b, 8'h00});
		for (int i = 0; i < 8; i++) begin
			if (modbus) begin
				c = c[0] ? ((c >> 1) ^ POLY_MODBUS) : (c >> 1);
			end else begin
				c = c[15] ? ((c << 1) ^ POLY_CCITT) : (c << 1);
			end
		end
		return c;
	endfunction

endpackage

/* rtl/crc16hx_front.sv */
`timescale 1ns / 1ps
// Front end: trailer delay line and frame counter; classifies each character.
// Depends on crc16hx_pkg.
module crc16hx_front
	import crc16hx_pkg::*;
#(
	parameter int TRAILER_BYTES = TRAILER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       crc_mode,
	output entry_t     entry
);

	localparam int CntW = $clog2(TRAILER_BYTES + 2);
	localparam logic [CntW-1:0] CntTr  = CntW'(TRAILER_BYTES);
	localparam logic [CntW-1:0] CntMax = CntW'(TRAILER_BYTES + 1);

	logic [CntW-1:0] count_q;
	logic [7:0]      delay_q  [TRAILER_BYTES];
	logic [7:0]      dly_next [TRAILER_BYTES];
	logic            full_run;

	assign full_run = (count_q >= CntTr);

	always_comb begin
		for (int i = 0; i < TRAILER_BYTES - 1; i++) begin
			if (full_run) begin
				dly_next[i] = delay_q[i+1];
			end else if (count_q == CntW'(i)) begin
				dly_next[i] = data_byte;
			end else begin
				dly_next[i] = delay_q[i];
			end
		end
		if (full_run || count_q == CntW'(TRAILER_BYTES - 1)) begin
			dly_next[TRAILER_BYTES-1] = data_byte;
		end else begin
			dly_next[TRAILER_BYTES-1] = delay_q[TRAILER_BYTES-1];
		end
	end

	always_comb begin
		entry.crc_en      = full_run;
		entry.crc_byte    = delay_q[0];
		entry.modbus      = crc_mode;
		entry.last        = last_byte;
		entry.short_frame = (count_q < CntTr);
		for (int k = 0; k < CMP_DIGITS; k++) begin
			entry.trailer[k] = dly_next[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q <= '0;
			end else if (count_q != CntMax) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < TRAILER_BYTES; i++) begin
				delay_q[i] <= dly_next[i];
			end
		end
	end

endmodule

/* rtl/crc16hx_fifo.sv */
`timescale 1ns / 1ps
// Short request queue between front and back ends.
// Depends on crc16hx_pkg.
module crc16hx_fifo
	import crc16hx_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	output logic   not_full,
	input  logic   pop,
	output logic   not_empty,
	output entry_t rd_entry
);

	localparam int PtrW = $clog2(QDEPTH);
	localparam int CntW = $clog2(QDEPTH + 1);

	entry_t          mem_q [QDEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] cnt_q;

	assign not_full  = (cnt_q != CntW'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (not_full || pop))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue pop while empty");
`endif

endmodule

/* rtl/crc16hx_back.sv */
`timescale 1ns / 1ps
// Back end: CRC register, hex trailer compare and result output register.
// Depends on crc16hx_pkg.
module crc16hx_back
	import crc16hx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  entry_t      q_entry,
	output logic        q_pop,
	output logic        res_valid,
	input  logic        res_ready,
	output status_t     res_status,
	output logic [15:0] res_crc
);

	logic [15:0] crc_q;
	logic [15:0] crc_next;
	logic        out_valid_q;
	status_t     out_status_q;
	logic [15:0] out_crc_q;
	logic        same;
	status_t     status;

	assign crc_next = q_entry.crc_en ? crc_step(crc_q, q_entry.crc_byte, q_entry.modbus)
	                                 : crc_q;

	always_comb begin
		same = 1'b1;
		for (int k = 0; k < CMP_DIGITS; k++) begin
			if (q_entry.trailer[k] != HEX_CHAR[crc_next[15-4*k -: 4]]) same = 1'b0;
		end
		if (q_entry.short_frame) status = ST_SHORT;
		else if (same)           status = ST_MATCH;
		else                     status = ST_MISMATCH;
	end

	// results wait in the output register; non-last characters never stall
	assign q_pop = q_valid && (!q_entry.last || !out_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q       <= CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) crc_q <= q_entry.last ? CRC_INIT : crc_next;
			if (q_pop && q_entry.last) out_valid_q <= 1'b1;
			else if (res_ready)        out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_entry.last) begin
			out_status_q <= status;
			out_crc_q    <= crc_next;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_status = out_status_q;
	assign res_crc    = out_crc_q;

`ifndef NO_ASSERTIONS
	a_crc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_entry.last) |=> (crc_q == CRC_INIT))
		else $error("CRC not reinitialized after frame end");
	a_short_init: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_entry.last && q_entry.short_frame) |-> (crc_q == CRC_INIT))
		else $error("short frame with CRC already advanced");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !res_ready) |-> !(q_pop && q_entry.last))
		else $error("result overwritten while stalled");
`endif

endmodule

/* rtl/crc16_hex_trailer_frame_check_unit.sv */
`timescale 1ns / 1ps
// Top level of the CRC-16 hex trailer frame checker.
// Depends on crc16hx_pkg, crc16hx_front, crc16hx_fifo, crc16hx_back.
//
// Usage:
//   Slave stream (s_*) carries one frame character per request; s_tlast marks
//   the final character. The last TRAILER_BYTES characters are the trailer and
//   are held back in a delay line; only earlier characters enter the CRC.
//   On the last character one result request leaves on the master stream:
//   status (match, mismatch, or short frame below TRAILER_BYTES+1 characters)
//   and the CRC over the payload. Other characters produce nothing.
//   APB register 0 (bit 0) selects CCITT-FALSE (0) or MODBUS (1); write it
//   only while no frame is in flight.
// Timing:
//   One character per cycle sustained while results are taken. The front end
//   (delay line, counter) classifies each character into a 2-entry queue; the
//   back end applies the unrolled one-byte CRC update and, on the last
//   character, the hex compare. m_tvalid is set in the output register when the
//   last character leaves the queue. On a receiver stall the result waits there;
//   characters still flow until the next last one blocks the queue head, then
//   s_tready drops once one more character has entered the queue.
// Reset: CRC = 0xFFFF, counter and queue empty, mode = CCITT. No clearing pass.
module crc16_hex_trailer_frame_check_unit
	import crc16hx_pkg::*;
#(
	parameter int TRAILER_BYTES = TRAILER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// slave stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	// master stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [1:0] check_status, [17:2] crc_value, rest zero
	// APB configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic        crc_mode_q;
	logic        accept;
	logic        q_not_full;
	logic        q_not_empty;
	logic        q_pop;
	entry_t      fe_entry;
	entry_t      be_entry;
	status_t     res_status;
	logic [15:0] res_crc;

	// config register: single word at address 0
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CRC_MODE) ? {31'd0, crc_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_CRC_MODE) begin
			crc_mode_q <= pwdata[0];
		end
	end

	assign s_tready = q_not_full;
	assign accept   = s_tvalid && s_tready;

	crc16hx_front #(.TRAILER_BYTES(TRAILER_BYTES)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.crc_mode  (crc_mode_q),
		.entry     (fe_entry)
	);

	crc16hx_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.wr_entry  (fe_entry),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_entry  (be_entry)
	);

	crc16hx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_entry    (be_entry),
		.q_pop      (q_pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_status (res_status),
		.res_crc    (res_crc)
	);

	assign m_tdata = {6'd0, res_crc, res_status};

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the CRC-16 hex trailer frame checker.
// Depends on crc16hx_pkg and crc16_hex_trailer_frame_check_unit from rtl/.
module testbench;
	import crc16hx_pkg::*;

	localparam int TB_TRAILER = TRAILER_BYTES_DEF;
	localparam int MAX_PRINTS = 40;

	// kinds of frame the random part builds
	typedef enum int {
		FR_GOOD,       // correct upper-case hex trailer
		FR_BAD_DIGIT,  // one compared digit replaced by a random byte
		FR_LOWER,      // hex letters in lower case
		FR_ZERO,       // one compared digit replaced by a zero byte
		FR_NOISE,      // whole trailer random
		FR_SHORT       // fewer characters than trailer plus one
	} frame_kind_t;

	// one expected result: status and CRC over the payload
	typedef struct {
		status_t     status;
		logic [15:0] crc;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        s_tlast;   // last_byte
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // [1:0] check_status, [17:2] crc_value, [23:18] zero
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	crc16_hex_trailer_frame_check_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// Predictor state: running CRC, the six-character hold-back line,
	// the saturating character count and the selected mode.
	logic [15:0] run_crc;
	logic [7:0]  held_chars [TB_TRAILER];
	int          held_cnt;
	logic        mode_now;

	verdict_t    pending_verdicts [$];

	int          n_errors;
	int          n_chars;
	int          n_results;
	int          n_match;
	int          n_mismatch;
	int          n_short;
	int          n_mode_writes;
	int          stall_cycles;

	// traffic shaping: calm is shared by the sender and the receiver
	bit          calm;          // no gaps on either side
	int          hold_request;  // receiver holds m_tready low this many cycles

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("crc16_hex_trailer_frame_check_unit: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// One character through the CRC, either MSB-first 0x1021 or the
	// reflected 0xA001 form.
	function automatic logic [15:0] crc_next(logic [15:0] c, logic [7:0] b, logic modbus);
		logic [15:0] r;
		r = c;
		if (modbus) begin
			r[7:0] = r[7:0] ^ b;
			repeat (8) r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
		end else begin
			r[15:8] = r[15:8] ^ b;
			repeat (8) r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
		end
		return r;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] nib);
		return (nib < 4'd10) ? (8'h30 + 8'(nib)) : (8'h41 + 8'(nib) - 8'd10);
	endfunction

	function automatic void clear_frame();
		run_crc  = CRC_INIT;
		held_cnt = 0;
		for (int i = 0; i < TB_TRAILER; i++)
			held_chars[i] = 8'h00;
	endfunction

	// Absorb one accepted character; on the last one queue the verdict.
	function automatic void absorb_char(logic [7:0] b, logic is_last);
		verdict_t v;
		bit       same;
		if (held_cnt >= TB_TRAILER) begin
			run_crc = crc_next(run_crc, held_chars[0], mode_now);
			for (int i = 0; i + 1 < TB_TRAILER; i++)
				held_chars[i] = held_chars[i + 1];
			held_chars[TB_TRAILER - 1] = b;
		end else begin
			held_chars[held_cnt] = b;
		end
		if (held_cnt < TB_TRAILER + 1)
			held_cnt++;
		if (is_last) begin
			v.crc = run_crc;
			if (held_cnt < TB_TRAILER + 1) begin
				v.status = ST_SHORT;
			end else begin
				same = 1'b1;
				for (int i = 0; i < CMP_DIGITS; i++)
					if (held_chars[i] != hex_char(run_crc[15 - 4 * i -: 4]))
						same = 1'b0;
				v.status = same ? ST_MATCH : ST_MISMATCH;
			end
			pending_verdicts.push_back(v);
			clear_frame();
		end
	endfunction

	// ------------------------------------------------------------------
	// Mismatch reporting (one line each, printing capped, all counted)
	// ------------------------------------------------------------------
	task automatic report_error(input string what, input longint got, input longint want);
		n_errors++;
		if (n_errors <= MAX_PRINTS)
			$display("ERROR @%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// Result checker: every accepted result against the oldest verdict
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_verdicts.size() == 0) begin
				report_error("unexpected result", m_tdata, 0);
			end else begin
				verdict_t v;
				v = pending_verdicts.pop_front();
				n_results++;
				case (v.status)
					ST_MATCH:    n_match++;
					ST_MISMATCH: n_mismatch++;
					default:     n_short++;
				endcase
				if (m_tdata[1:0] != v.status)
					report_error("check_status", m_tdata[1:0], v.status);
				if (m_tdata[17:2] != v.crc)
					report_error("crc_value", m_tdata[17:2], v.crc);
				if (m_tdata[23:18] != 6'd0)
					report_error("tdata padding", m_tdata[23:18], 0);
			end
		end
	end

	// count cycles where the input is held off by a full block
	always @(posedge clk)
		if (arst_n && s_tvalid && !s_tready)
			stall_cycles++;

	// ------------------------------------------------------------------
	// Receiver: random ready pattern, long hold on request
	// ------------------------------------------------------------------
	initial begin
		int r;
		int run;
		int held_for;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				m_tready = 1'b0;
				held_for = 0;
				while (held_for < hold_request) begin
					@(negedge clk);
					held_for++;
				end
				hold_request = 0;
				m_tready = 1'b1;
			end else if (calm) begin
				m_tready = 1'b1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					m_tready = 1'b1;
					run = $urandom_range(1, 8);
				end else if (r < 95) begin
					m_tready = 1'b0;
					run = $urandom_range(1, 3);
				end else begin
					m_tready = 1'b0;
					run = $urandom_range(10, 40);
				end
				repeat (run - 1) @(negedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one character request; valid stays high on return so that
	// back-to-back requests need no drop.
	task automatic push_char(input logic [7:0] b, input logic is_last);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = b;
		s_tlast  = is_last;
		forever begin
			@(posedge clk);
			if (s_tready)
				break;
		end
		n_chars++;
		absorb_char(b, is_last);
	endtask

	// Build a frame of the given kind in the current mode and send it.
	task automatic send_frame(input frame_kind_t kind, input int pay_len);
		logic [7:0]  chars [$];
		logic [15:0] c;
		logic [7:0]  b;
		int          pos;
		chars = {};
		c = CRC_INIT;
		if (kind == FR_SHORT) begin
			repeat ($urandom_range(1, TB_TRAILER))
				chars.push_back(8'($urandom));
		end else begin
			repeat (pay_len) begin
				b = 8'($urandom);
				chars.push_back(b);
				c = crc_next(c, b, mode_now);
			end
			for (int i = 0; i < CMP_DIGITS; i++)
				chars.push_back(hex_char(c[15 - 4 * i -: 4]));
			// characters past the compared digits are ignored by the check
			for (int i = CMP_DIGITS; i < TB_TRAILER; i++)
				chars.push_back(8'($urandom));
			pos = pay_len + $urandom_range(0, CMP_DIGITS - 1);
			case (kind)
				FR_BAD_DIGIT: chars[pos] = 8'($urandom);
				FR_ZERO:      chars[pos] = 8'h00;
				FR_LOWER: begin
					for (int i = pay_len; i < pay_len + CMP_DIGITS; i++)
						if (chars[i] >= 8'h41)
							chars[i] = chars[i] | 8'h20;
				end
				FR_NOISE: begin
					for (int i = pay_len; i < pay_len + TB_TRAILER; i++)
						chars[i] = 8'($urandom);
				end
				default: ;
			endcase
		end
		for (int i = 0; i < chars.size(); i++)
			push_char(chars[i], i == chars.size() - 1);
	endtask

	// Wait until every verdict has come back, then let the pipe drain.
	task automatic wait_idle();
		int waited;
		@(negedge clk);
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		waited = 0;
		while (pending_verdicts.size() != 0) begin
			@(posedge clk);
			waited++;
			if (waited > 100_000) begin
				$display("crc16_hex_trailer_frame_check_unit: mismatch");
				$finish;
			end
		end
		// allow margin after the last result
		repeat (8) @(posedge clk);
	endtask

	// APB write of the mode register, only with the block idle.
	task automatic write_mode(input logic m);
		wait_idle();
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = 3'(int'(REG_CRC_MODE) * 4);
		// upper bits random: only bit 0 is meaningful
		pwdata  = {31'($urandom), m};
		@(negedge clk);
		penable = 1'b1;
		forever begin
			@(posedge clk);
			if (pready)
				break;
		end
		mode_now = m;
		n_mode_writes++;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Frames below trailer plus one characters, extremes of the data byte,
	// including the one-character frame and the six-character boundary.
	task automatic test_short_frames();
		push_char(8'hFF, 1'b1);
		for (int i = 0; i < TB_TRAILER; i++)
			push_char((i % 2 == 0) ? 8'h00 : 8'hFF, i == TB_TRAILER - 1);
	endtask

	// Shortest full frame: one payload character, correct trailer.
	// Then hex letters in lower case, which the check treats as a mismatch.
	task automatic test_minimal_frames();
		send_frame(FR_GOOD, 1);
		send_frame(FR_LOWER, 1);
	endtask

	// Receiver holds off for a long counted stretch while the sender
	// keeps offering frames with short payloads back to back: queue fills, input stalls.
	task automatic test_backpressure();
		wait_idle();
		calm = 1'b1;
		hold_request = 300;
		repeat (8)
			send_frame(FR_GOOD, $urandom_range(1, 3));
		calm = 1'b0;
	endtask

	// Random frames in one mode until about the given number of characters.
	task automatic test_random_phase(input logic m, input int budget);
		int          start;
		int          r;
		int          len;
		frame_kind_t kind;
		int          frames;
		write_mode(m);
		start  = n_chars;
		frames = 0;
		while (n_chars - start < budget) begin
			// a calm stretch at the start of each phase
			calm = (frames < 4);
			r = $urandom_range(0, 99);
			if (r < 55)      kind = FR_GOOD;
			else if (r < 65) kind = FR_BAD_DIGIT;
			else if (r < 72) kind = FR_LOWER;
			else if (r < 78) kind = FR_ZERO;
			else if (r < 88) kind = FR_NOISE;
			else             kind = FR_SHORT;
			r = $urandom_range(0, 99);
			if (r < 3)       len = 0;
			else if (r < 95) len = $urandom_range(1, 12);
			else             len = $urandom_range(40, 160);
			send_frame(kind, len);
			frames++;
		end
		calm = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tdata       = 8'h00;
		s_tlast       = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = 3'd0;
		pwdata        = 32'd0;
		calm          = 1'b0;
		hold_request  = 0;
		n_errors      = 0;
		n_chars       = 0;
		n_results     = 0;
		n_match       = 0;
		n_mismatch    = 0;
		n_short       = 0;
		n_mode_writes = 0;
		stall_cycles  = 0;
		mode_now      = 1'b0;
		clear_frame();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset mode is CCITT; write it once explicitly as well
		test_short_frames();
		test_minimal_frames();
		write_mode(1'b0);
		test_minimal_frames();

		test_random_phase(1'b1, 430);
		test_random_phase(1'b0, 430);
		test_backpressure();
		test_random_phase(1'b1, 430);
		test_random_phase(1'b0, 430);

		wait_idle();
		repeat (20) @(posedge clk);

		$display("Covered %0d characters, %0d results (%0d match, %0d mismatch, %0d short).",
			n_chars, n_results, n_match, n_mismatch, n_short);
		$display("Both CRC modes over %0d register writes, %0d input stall cycles.",
			n_mode_writes, stall_cycles);
		if (n_errors == 0 && pending_verdicts.size() == 0) begin
			$display("crc16_hex_trailer_frame_check_unit: match");
		end else begin
			$display("crc16_hex_trailer_frame_check_unit: mismatch");
		end
		$finish;
	end

endmodule

/* sim.f */
rtl/crc16hx_pkg.sv
rtl/crc16hx_front.sv
rtl/crc16hx_fifo.sv
rtl/crc16hx_back.sv
rtl/crc16_hex_trailer_frame_check_unit.sv
verif/testbench.sv
